>>> design/llhi_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Least-loaded holder index: shared types and constants
// Table sizes, field widths, opcodes, sequencer states and the request
// bundles that drive the entry and link-count memories.
// ---------------------------------------------------------------------------
package llhi_pkg;

  // Table sizes
  localparam int TABLE_ENTRIES = 1024;
  localparam int HOLDERS       = 1024;
  localparam int FILES         = 1024;

  localparam int ENTRY_AW  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int HOLDER_AW = $clog2(HOLDERS);

  // Field widths
  localparam int OP_W    = 2;
  localparam int FILE_W  = 10;
  localparam int SEG_W   = 16;
  localparam int HOLD_W  = 10;
  localparam int CNT_W   = 16;
  localparam int LIMIT_W = 15;
  localparam int ENTRY_W = FILE_W + SEG_W + HOLD_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  // One stored table entry
  typedef struct packed {
    logic [HOLD_W-1:0] holder;
    logic [SEG_W-1:0]  segment;
    logic [FILE_W-1:0] file;
  } entry_t;

  // One input item
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [FILE_W-1:0] file_id;
    logic [SEG_W-1:0]  segment_id;
    logic [HOLD_W-1:0] holder_id;
    logic [CNT_W-1:0]  new_link_count;
  } item_t;

  // One result item
  typedef struct packed {
    logic              found;
    logic [HOLD_W-1:0] best_holder;
    logic              status;
  } result_t;

  // Entry memory request
  typedef struct packed {
    logic                we;
    logic [ENTRY_AW-1:0] waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic                re;
    logic [ENTRY_AW-1:0] raddr;
  } ent_req_t;

  // Link-count memory request
  typedef struct packed {
    logic                 we;
    logic [HOLDER_AW-1:0] waddr;
    logic [CNT_W-1:0]     wdata;
    logic                 re;
    logic [HOLDER_AW-1:0] raddr;
  } lnk_req_t;

endpackage
`default_nettype wire

>>> design/least_loaded_holder_index.sv
`default_nettype none
// Scan: the sequencer reads one stored entry a cycle; an accepted item is worked through
//   and its result handed to the output register before s_tready rises for the next
//   item, so items do not overlap. An item with an unused opcode skips the scan.
// Reset: rst is synchronous; afterwards a clearing pass zeroes the 1024 link
//   counters with s_tready low; cfg writes are taken meanwhile.
// ---------------------------------------------------------------------------
// Least-loaded holder index
// Stream wrapper: configuration register, entry and link-count memories,
// scan sequencer and the output register.
// ---------------------------------------------------------------------------
module least_loaded_holder_index import llhi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [14:0] cfg_wdata,      // link_limit
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,        // file_id, segment_id, holder_id, new_link_count
  input  wire logic [1:0]  s_tuser,        // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata         // found, best_holder, status
);

  logic [LIMIT_W-1:0] link_limit;
  item_t              in_item;
  result_t            res;
  logic               res_valid;
  logic               res_ready;
  ent_req_t           ent_req;
  lnk_req_t           lnk_req;
  logic [ENTRY_W-1:0] ent_rdata;
  logic [CNT_W-1:0]   lnk_rdata;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_limit <= LIMIT_RESET;
    end else if (cfg_wen) begin
      link_limit <= cfg_wdata;
    end
  end

  // Unpack the input transfer.
  assign in_item.opcode         = s_tuser;
  assign in_item.file_id        = s_tdata[9:0];
  assign in_item.segment_id     = s_tdata[25:10];
  assign in_item.holder_id      = s_tdata[35:26];
  assign in_item.new_link_count = s_tdata[51:36];

  llhi_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .link_limit (link_limit),
    .in_valid   (s_tvalid),
    .in_item    (in_item),
    .in_ready   (s_tready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ent_req    (ent_req),
    .ent_rdata  (ent_rdata),
    .lnk_req    (lnk_req),
    .lnk_rdata  (lnk_rdata)
  );

  // Entry table memory.
  llhi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_req.we),
    .waddr (ent_req.waddr),
    .wdata (ent_req.wdata),
    .re    (ent_req.re),
    .raddr (ent_req.raddr),
    .rdata (ent_rdata)
  );

  // Link-count memory.
  llhi_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HOLDERS)
  ) u_link_ram (
    .clk   (clk),
    .we    (lnk_req.we),
    .waddr (lnk_req.waddr),
    .wdata (lnk_req.wdata),
    .re    (lnk_req.re),
    .raddr (lnk_req.raddr),
    .rdata (lnk_rdata)
  );

  // Output register: loads when empty or when its transfer completes.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'b0, res.status, res.best_holder, res.found};
    end
  end

endmodule
`default_nettype wire

>>> design/llhi_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module llhi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/llhi_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Least-loaded holder index: scan sequencer
// Walks the stored entries one per cycle through the entry memory, compacts
// the table on insert and delete, and looks up link counts on search.
// ---------------------------------------------------------------------------
module llhi_engine import llhi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [LIMIT_W-1:0] link_limit,
  input  wire logic               in_valid,
  input  wire item_t              in_item,
  output logic                    in_ready,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output result_t                 res,
  output ent_req_t                ent_req,
  input  wire logic [ENTRY_W-1:0] ent_rdata,
  output lnk_req_t                lnk_req,
  input  wire logic [CNT_W-1:0]   lnk_rdata
);

  state_t state, state_next;

  item_t                item;
  logic [FILL_W-1:0]    fill_count;
  logic [FILL_W-1:0]    rd_cnt;
  logic [FILL_W-1:0]    wr_cnt;
  logic [HOLDER_AW-1:0] clr_cnt;
  logic                 s1_valid;
  logic                 s2_valid;
  logic [HOLD_W-1:0]    s2_holder;
  logic                 found;
  logic [CNT_W-1:0]     min_links;
  logic [HOLD_W-1:0]    best;
  logic                 status;

  entry_t            rd_entry;
  logic              in_fire;
  logic              in_go;
  logic              item_search;
  logic              key_match;
  logic              full_match;
  logic              rd_issue;
  logic              scan_done;
  logic              ent_holder_ok;
  logic [CNT_W-1:0]  bound;
  logic              lk_better;
  logic              table_full;
  logic [HOLD_W-1:0] new_holder;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rd_entry = entry_t'(ent_rdata);

  // Whether an accepted item has any work to do.
  always_comb begin
    in_go = 1'b0;
    if (32'(in_item.file_id) < 32'(FILES)) begin
      case (in_item.opcode)
        OP_INSERT, OP_DELETE: in_go = 32'(in_item.holder_id) < 32'(HOLDERS);
        OP_SEARCH:            in_go = 1'b1;
        default:              in_go = 1'b0;
      endcase
    end
  end

  // Scan datapath decodes.
  assign item_search   = (item.opcode == OP_SEARCH);
  assign key_match     = (rd_entry.file == item.file_id) &&
                         (rd_entry.segment == item.segment_id);
  assign full_match    = key_match && (rd_entry.holder == item.holder_id);
  assign ent_holder_ok = 32'(rd_entry.holder) < 32'(HOLDERS);
  assign rd_issue      = (state == ST_SCAN) && (rd_cnt < fill_count);
  assign scan_done     = (state == ST_SCAN) && (rd_cnt == fill_count) &&
                         !s1_valid && !s2_valid;
  assign bound         = {link_limit, 1'b0};
  assign lk_better     = (lnk_rdata <= bound) && (!found || (lnk_rdata < min_links));
  assign table_full    = (wr_cnt == FILL_W'(TABLE_ENTRIES));
  assign new_holder    = item.holder_id;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == HOLDER_AW'(HOLDERS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_fire) state_next = in_go ? ST_SCAN : ST_DONE;
      ST_SCAN:   if (scan_done) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_DONE;
      ST_DONE:   if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory requests and result handshake.
  always_comb begin
    ent_req       = '0;
    lnk_req       = '0;
    res_valid     = 1'b0;
    ent_req.re    = rd_issue;
    ent_req.raddr = rd_cnt[ENTRY_AW-1:0];
    case (state)
      ST_CLEAR: begin
        lnk_req.we    = 1'b1;
        lnk_req.waddr = clr_cnt;
        lnk_req.wdata = '0;
      end
      ST_SCAN: begin
        if (s1_valid && !item_search && !full_match) begin
          ent_req.we    = 1'b1;
          ent_req.waddr = wr_cnt[ENTRY_AW-1:0];
          ent_req.wdata = ent_rdata;
        end
        lnk_req.re    = s1_valid && item_search && key_match && ent_holder_ok;
        lnk_req.raddr = HOLDER_AW'(rd_entry.holder);
      end
      ST_FINISH: begin
        case (item.opcode)
          OP_INSERT: begin
            ent_req.we    = !table_full;
            ent_req.waddr = wr_cnt[ENTRY_AW-1:0];
            ent_req.wdata = {item.holder_id, item.segment_id, item.file_id};
            lnk_req.we    = !table_full;
            lnk_req.waddr = HOLDER_AW'(new_holder);
            lnk_req.wdata = item.new_link_count;
          end
          OP_SEARCH: begin
            lnk_req.we    = found && (min_links != COUNT_MAX);
            lnk_req.waddr = HOLDER_AW'(best);
            lnk_req.wdata = min_links + CNT_W'(1);
          end
          default: ;
        endcase
      end
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.found       = found;
  assign res.best_holder = best;
  assign res.status      = status;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      fill_count <= '0;
      clr_cnt    <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= rd_issue;
      s2_valid <= lnk_req.re;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + HOLDER_AW'(1);
      end
      if (state == ST_FINISH) begin
        case (item.opcode)
          OP_INSERT: fill_count <= table_full ? wr_cnt : wr_cnt + FILL_W'(1);
          OP_DELETE: fill_count <= wr_cnt;
          default: ;
        endcase
      end
    end
  end

  // Item, counters and running best.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item      <= in_item;
      rd_cnt    <= '0;
      wr_cnt    <= '0;
      found     <= 1'b0;
      best      <= '0;
      min_links <= '0;
      status    <= 1'b0;
    end else begin
      if (rd_issue) begin
        rd_cnt <= rd_cnt + FILL_W'(1);
      end
      if (ent_req.we && state == ST_SCAN) begin
        wr_cnt <= wr_cnt + FILL_W'(1);
      end
      if (s2_valid && lk_better) begin
        found     <= 1'b1;
        min_links <= lnk_rdata;
        best      <= s2_holder;
      end
      if (state == ST_FINISH && item.opcode == OP_INSERT) begin
        status <= table_full;
      end
    end
    if (lnk_req.re) begin
      s2_holder <= rd_entry.holder;
    end
  end

  // Fill count never exceeds the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(TABLE_ENTRIES))
    else $error("fill count above table size");

  // Compaction writes never overtake the read pointer.
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (wr_cnt <= rd_cnt))
    else $error("compaction write pointer ahead of read pointer");

  // A compaction write never hits the entry being read in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && ent_req.we && ent_req.re) |-> (ent_req.waddr != ent_req.raddr))
    else $error("entry memory read and write collide");

  // No item is taken while the link counters are being cleared.
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!in_ready && !res_valid))
    else $error("activity during link clear");

  // The link-count memory is read only while searching.
  a_link_read: assert property (@(posedge clk) disable iff (rst)
    lnk_req.re |-> (state == ST_SCAN && item_search))
    else $error("link read outside a search scan");

endmodule
`default_nettype wire
